// ===== design/bmcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared types, constants and code tables of the bitmask code decompressor.
// ----------------------------------------------------------------------------
package bmcd_pkg;

    localparam int WORD_W      = 32;
    localparam int DICT_N      = 8;
    localparam int DICT_IDX_W  = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int BUF_W       = 66;
    localparam int FILL_W      = 7;
    localparam int LEN_W       = 6;
    localparam int IN_DEPTH    = 2;
    localparam int OUT_DEPTH   = 2;

    typedef enum logic [2:0] {
        TAG_REPEAT    = 3'd0,
        TAG_MASK4     = 3'd1,
        TAG_FLIP1     = 3'd2,
        TAG_FLIP2     = 3'd3,
        TAG_FLIP_PAIR = 3'd4,
        TAG_DICT      = 3'd5,
        TAG_RAW       = 3'd6,
        TAG_PAD       = 3'd7
    } tag_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DECODE,
        ST_REPEAT,
        ST_FLUSH
    } dec_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              final_word;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] instruction;
        logic              run_end;
        logic              stream_done;
    } out_word_t;

    function automatic logic [LEN_W-1:0] code_length(input tag_t tag);
        logic [LEN_W-1:0] len;
        unique case (tag)
            TAG_REPEAT:    len = 6'd5;
            TAG_MASK4:     len = 6'd15;
            TAG_FLIP1:     len = 6'd11;
            TAG_FLIP2:     len = 6'd11;
            TAG_FLIP_PAIR: len = 6'd16;
            TAG_DICT:      len = 6'd6;
            TAG_RAW:       len = 6'd35;
            default:       len = 6'd3;
        endcase
        return len;
    endfunction

endpackage

// ===== design/bitmask_code_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmask_code_decompressor
// Decompresses a bitmask/dictionary coded instruction stream.
// ----------------------------------------------------------------------------
// Compressed words enter through a small input queue and are appended to a
// 66-bit buffer; the decoder then takes one complete code per cycle unless
// the output queue is full, and a repeat code emits its extra copies from a
// repeat state before decoding goes on. Each word is loaded, decoded until
// no complete code is left (or padding is met) and then closed in a flush
// state, which releases the word's last pending result with the end flags;
// results leave through an output queue. Words that arrive after padding or
// after the final word are consumed silently.
module bitmask_code_decompressor #(
    parameter int IN_DEPTH  = bmcd_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = bmcd_pkg::OUT_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bmcd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bmcd_pkg::WORD_W-1:0]           cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic [bmcd_pkg::WORD_W-1:0]           packed_word,
    input  logic                                  final_word,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [bmcd_pkg::WORD_W-1:0]           instruction,
    output logic                                  run_end,
    output logic                                  stream_done
);

    bmcd_pkg::in_word_t  in_wdata, in_rdata;
    bmcd_pkg::out_word_t out_wdata, out_rdata;
    logic                in_empty, in_pop;
    logic                out_full, out_push;
    logic                cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && !cfg_index[bmcd_pkg::CFG_IDX_W-1];
    assign in_wdata  = '{packed_word: packed_word, final_word: final_word};

    bmcd_fifo #(
        .WIDTH ($bits(bmcd_pkg::in_word_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_wdata),
        .full  (full),
        .pop   (in_pop),
        .rdata (in_rdata),
        .empty (in_empty)
    );

    bmcd_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_sel  (cfg_index[bmcd_pkg::DICT_IDX_W-1:0]),
        .cfg_data (cfg_data),
        .in_word  (in_rdata),
        .in_empty (in_empty),
        .in_pop   (in_pop),
        .out_word (out_wdata),
        .out_full (out_full),
        .out_push (out_push)
    );

    bmcd_fifo #(
        .WIDTH ($bits(bmcd_pkg::out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign instruction = out_rdata.instruction;
    assign run_end     = out_rdata.run_end;
    assign stream_done = out_rdata.stream_done;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_push && out_full))
        else $error("decoder wrote a result into a full output queue");

    a_done_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_done) |-> run_end)
        else $error("stream end flagged on a result that does not close a word");

    a_pop_only_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_pop && in_empty) |-> 1'b0)
        else $error("decoder took a word from an empty input queue");

endmodule

// ===== design/bmcd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_fifo
// Small register-based queue with a push/full and pop/empty handshake.
// ----------------------------------------------------------------------------
module bmcd_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/bmcd_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcd_decoder
// Bit buffer, code parser and instruction builder; one code per cycle unless repeating or the output queue is full.
// ----------------------------------------------------------------------------
module bmcd_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [bmcd_pkg::DICT_IDX_W-1:0]        cfg_sel,
    input  logic [bmcd_pkg::WORD_W-1:0]            cfg_data,
    input  bmcd_pkg::in_word_t                     in_word,
    input  logic                                   in_empty,
    output logic                                   in_pop,
    output bmcd_pkg::out_word_t                    out_word,
    input  logic                                   out_full,
    output logic                                   out_push
);

    logic [bmcd_pkg::WORD_W-1:0] dict_reg [bmcd_pkg::DICT_N];

    bmcd_pkg::dec_state_t              state_reg, state_next;
    logic [bmcd_pkg::BUF_W-1:0]        buf_reg, buf_next;
    logic [bmcd_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [bmcd_pkg::WORD_W-1:0]       prev_reg, prev_next;
    logic [bmcd_pkg::WORD_W-1:0]       pend_reg, pend_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [1:0]                        rep_reg, rep_next;
    logic                              last_reg, last_next;
    logic                              finished_reg, finished_next;

    bmcd_pkg::tag_t                    tag;
    logic [bmcd_pkg::LEN_W-1:0]        len;
    logic [bmcd_pkg::DICT_IDX_W-1:0]   sel;
    logic [bmcd_pkg::WORD_W-1:0]       base;
    logic [bmcd_pkg::WORD_W-1:0]       inst;
    logic [4:0]                        pos_p;
    logic [4:0]                        pos_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bmcd_pkg::DICT_N; i++)
            begin
                dict_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            dict_reg[cfg_sel] <= cfg_data;
        end
    end

    // Fields sit at the top of the buffer, right after the three tag bits.
    assign tag   = bmcd_pkg::tag_t'(buf_reg[65:63]);
    assign len   = bmcd_pkg::code_length(tag);
    assign pos_p = buf_reg[62:58];
    assign pos_q = buf_reg[57:53];

    always_comb
    begin
        unique case (tag)
            bmcd_pkg::TAG_MASK4:     sel = buf_reg[53:51];
            bmcd_pkg::TAG_FLIP1,
            bmcd_pkg::TAG_FLIP2:     sel = buf_reg[57:55];
            bmcd_pkg::TAG_FLIP_PAIR: sel = buf_reg[52:50];
            default:                 sel = buf_reg[62:60];
        endcase
    end

    assign base = dict_reg[sel];

    always_comb
    begin
        unique case (tag)
            bmcd_pkg::TAG_MASK4:     inst = base ^ ({buf_reg[57:54], 28'd0} >> pos_p);
            bmcd_pkg::TAG_FLIP1:     inst = base ^ (32'h8000_0000 >> pos_p);
            bmcd_pkg::TAG_FLIP2:     inst = base ^ (32'hC000_0000 >> pos_p);
            bmcd_pkg::TAG_FLIP_PAIR: inst = base ^ (32'h8000_0000 >> pos_p)
                                                 ^ (32'h8000_0000 >> pos_q);
            bmcd_pkg::TAG_RAW:       inst = buf_reg[62:31];
            default:                 inst = base;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        buf_next        = buf_reg;
        fill_next       = fill_reg;
        prev_next       = prev_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rep_next        = rep_reg;
        last_next       = last_reg;
        finished_next   = finished_reg;
        in_pop          = 1'b0;
        out_push        = 1'b0;
        out_word        = '{instruction: pend_reg, run_end: 1'b0, stream_done: 1'b0};

        unique case (state_reg)
            bmcd_pkg::ST_LOAD:
            begin
                if (!in_empty)
                begin
                    in_pop = 1'b1;
                    // Words after the end of the stream are taken and dropped.
                    if (!finished_reg)
                    begin
                        buf_next  = buf_reg
                                  | ({in_word.packed_word, 34'd0} >> fill_reg);
                        fill_next = fill_reg + 7'd32;
                        last_next = in_word.final_word;
                        state_next = bmcd_pkg::ST_DECODE;
                    end
                end
            end

            bmcd_pkg::ST_DECODE:
            begin
                if (fill_reg < 7'd3)
                begin
                    state_next = bmcd_pkg::ST_FLUSH;
                end
                else if (tag == bmcd_pkg::TAG_PAD)
                begin
                    finished_next = 1'b1;
                    buf_next      = '0;
                    fill_next     = '0;
                    state_next    = bmcd_pkg::ST_FLUSH;
                end
                else if (fill_reg < {1'b0, len})
                begin
                    state_next = bmcd_pkg::ST_FLUSH;
                end
                else if (!(pend_valid_reg && out_full))
                begin
                    // The previous result is released only once a newer one
                    // exists, so that the last one can carry the end flags.
                    out_push        = pend_valid_reg;
                    buf_next        = buf_reg << len;
                    fill_next       = fill_reg - 7'(len);
                    pend_valid_next = 1'b1;
                    if (tag == bmcd_pkg::TAG_REPEAT)
                    begin
                        pend_next = prev_reg;
                        rep_next  = buf_reg[62:61];
                        if (buf_reg[62:61] != 2'd0)
                        begin
                            state_next = bmcd_pkg::ST_REPEAT;
                        end
                    end
                    else
                    begin
                        pend_next = inst;
                        prev_next = inst;
                    end
                end
            end

            bmcd_pkg::ST_REPEAT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    rep_next = rep_reg - 2'd1;
                    if (rep_reg == 2'd1)
                    begin
                        state_next = bmcd_pkg::ST_DECODE;
                    end
                end
            end

            bmcd_pkg::ST_FLUSH:
            begin
                out_word.run_end     = 1'b1;
                out_word.stream_done = finished_reg || last_reg;
                if (!(pend_valid_reg && out_full))
                begin
                    out_push        = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    state_next      = bmcd_pkg::ST_LOAD;
                    if (last_reg)
                    begin
                        finished_next = 1'b1;
                        buf_next      = '0;
                        fill_next     = '0;
                    end
                end
            end

            default:
            begin
                state_next = bmcd_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bmcd_pkg::ST_LOAD;
            buf_reg        <= '0;
            fill_reg       <= '0;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rep_reg        <= '0;
            last_reg       <= 1'b0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            buf_reg        <= buf_next;
            fill_reg       <= fill_next;
            prev_reg       <= prev_next;
            pend_valid_reg <= pend_valid_next;
            rep_reg        <= rep_next;
            last_reg       <= last_next;
            finished_reg   <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

// ===== dv/tb_bitmask_code_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmask_code_decompressor
// Self-checking testbench for the bitmask code decompressor. Compressed
// streams are built from whole codes with random fields and cut into 32-bit
// words. A software decoder predicts every instruction, and each popped word
// is compared field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bitmask_code_decompressor;

    localparam logic [bmcd_pkg::CFG_IDX_W-1:0] CFG_DICT_WORD0 = 4'd0;
    localparam logic [bmcd_pkg::CFG_IDX_W-1:0] CFG_UNUSED     = 4'd11;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [bmcd_pkg::WORD_W-1:0] word;
        logic                        last;
    } stream_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bmcd_pkg::WORD_W-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic [bmcd_pkg::WORD_W-1:0] packed_word = '0;
    logic final_word = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [bmcd_pkg::WORD_W-1:0] instruction;
    logic run_end;
    logic stream_done;

    bitmask_code_decompressor DUT (.*);

    always #5 clk = ~clk;

    // Stream under construction and the words waiting for the driver.
    bit                  code_bits[$];
    stream_word_t        word_q[$];
    bmcd_pkg::out_word_t expected_insts[$];

    // Decoder state used for prediction.
    logic [63:0]                 pend_bits = '0;
    int                          pend_fill = 0;
    logic [bmcd_pkg::WORD_W-1:0] last_inst = '0;
    logic [bmcd_pkg::WORD_W-1:0] dict_model[bmcd_pkg::DICT_N];
    bit                          stream_over = 1'b0;
    bmcd_pkg::out_word_t         word_results[$];

    int  errors = 0;
    int  words_in = 0;
    int  insts_checked = 0;
    int  dict_settings = 0;
    bit  took = 1'b0;
    int  burst_cnt = 4;
    int  gap_cnt = 0;
    bit  long_stall_req = 1'b0;
    int  stall_cnt = 0;
    int  rx_mode = 0;
    int  rx_cycle = 0;

    function automatic int code_bits_for(bmcd_pkg::tag_t t);
        case (t)
            bmcd_pkg::TAG_REPEAT:    return 5;
            bmcd_pkg::TAG_MASK4:     return 15;
            bmcd_pkg::TAG_FLIP1:     return 11;
            bmcd_pkg::TAG_FLIP2:     return 11;
            bmcd_pkg::TAG_FLIP_PAIR: return 16;
            bmcd_pkg::TAG_DICT:      return 6;
            bmcd_pkg::TAG_RAW:       return 35;
            default:                 return 3;
        endcase
    endfunction

    function automatic void push_pending(logic [63:0] v, int k);
        pend_bits = pend_bits | (v << (64 - pend_fill - k));
        pend_fill = pend_fill + k;
    endfunction

    function automatic void decode_pending();
        bmcd_pkg::tag_t              t;
        int                          len;
        logic [63:0]                 c;
        logic [bmcd_pkg::WORD_W-1:0] base;
        logic [bmcd_pkg::WORD_W-1:0] inst;
        bmcd_pkg::out_word_t         r;
        while (!stream_over && pend_fill >= 3) begin
            t = bmcd_pkg::tag_t'(pend_bits[63:61]);
            len = code_bits_for(t);
            if (t == bmcd_pkg::TAG_PAD) begin
                stream_over = 1'b1;
                pend_bits = '0;
                pend_fill = 0;
                return;
            end
            if (pend_fill < len)
                return;
            c = pend_bits >> (64 - len);
            pend_bits = pend_bits << len;
            pend_fill = pend_fill - len;
            base = dict_model[c[2:0]];
            if (t == bmcd_pkg::TAG_REPEAT) begin
                for (int i = 0; i <= c[1:0]; i++) begin
                    r.instruction = last_inst;
                    r.run_end = 1'b0;
                    r.stream_done = 1'b0;
                    word_results = {word_results, r};
                end
                continue;
            end
            case (t)
                bmcd_pkg::TAG_MASK4:
                    inst = base ^ ((bmcd_pkg::WORD_W'(c[6:3]) << 28) >> c[11:7]);
                bmcd_pkg::TAG_FLIP1:     inst = base ^ (32'h8000_0000 >> c[7:3]);
                bmcd_pkg::TAG_FLIP2:     inst = base ^ (32'hC000_0000 >> c[7:3]);
                bmcd_pkg::TAG_FLIP_PAIR: inst = base ^ (32'h8000_0000 >> c[12:8])
                                                     ^ (32'h8000_0000 >> c[7:3]);
                bmcd_pkg::TAG_DICT:      inst = base;
                default:                 inst = c[31:0];
            endcase
            last_inst = inst;
            r.instruction = inst;
            r.run_end = 1'b0;
            r.stream_done = 1'b0;
            word_results = {word_results, r};
        end
    endfunction

    function automatic void predict_word(logic [bmcd_pkg::WORD_W-1:0] w, logic last);
        int k1;
        int k2;
        bit done_now;
        word_results.delete();
        if (stream_over)
            return;
        k1 = (64 - pend_fill > 32) ? 32 : 64 - pend_fill;
        k2 = 32 - k1;
        if (k1 > 0)
            push_pending(64'(w >> (32 - k1)), k1);
        decode_pending();
        if (k2 > 0 && !stream_over) begin
            push_pending(64'(w & ((32'd1 << k2) - 1)), k2);
            decode_pending();
        end
        done_now = stream_over;
        if (last && !stream_over) begin
            stream_over = 1'b1;
            pend_bits = '0;
            pend_fill = 0;
            done_now = 1'b1;
        end
        if (word_results.size() > 0) begin
            word_results[word_results.size()-1].run_end = 1'b1;
            word_results[word_results.size()-1].stream_done = done_now;
        end
        foreach (word_results[i])
            expected_insts = {expected_insts, word_results[i]};
    endfunction

    // ---------------- stream building ----------------
    task automatic add_code(bmcd_pkg::tag_t t, logic [31:0] body);
        int n;
        n = code_bits_for(t) - 3;
        for (int i = 2; i >= 0; i--)
            code_bits = {code_bits, t[i]};
        for (int i = n - 1; i >= 0; i--)
            code_bits = {code_bits, body[i]};
    endtask

    task automatic add_raw(logic [31:0] v);
        add_code(bmcd_pkg::TAG_RAW, 32'd0);
        repeat (32) void'(code_bits.pop_back());
        for (int i = 31; i >= 0; i--)
            code_bits = {code_bits, v[i]};
    endtask

    task automatic pack_words(logic last);
        stream_word_t sw;
        while (code_bits.size() >= 32) begin
            for (int i = 31; i >= 0; i--)
                sw.word[i] = code_bits.pop_front();
            sw.last = last && (code_bits.size() < 32);
            word_q = {word_q, sw};
        end
    endtask

    // Close the stream on a word boundary with repeat and dictionary codes.
    task automatic align_stream();
        int r;
        int b;
        r = (32 - code_bits.size() % 32) % 32;
        if (r != 0) begin
            if (r < 20)
                r = r + 32;
            b = 0;
            while ((r - 6 * b) % 5 != 0)
                b++;
            for (int i = 0; i < b; i++)
                add_code(bmcd_pkg::TAG_DICT, $urandom_range(0, 7));
            for (int i = 0; i < (r - 6 * b) / 5; i++)
                add_code(bmcd_pkg::TAG_REPEAT, $urandom_range(0, 3));
        end
        pack_words(1'b0);
    endtask

    task automatic add_random_code();
        bmcd_pkg::tag_t t;
        t = bmcd_pkg::tag_t'($urandom_range(0, 6));
        if (t == bmcd_pkg::TAG_RAW)
            add_raw($urandom());
        else
            add_code(t, $urandom());
    endtask

    // ---------------- idle handling and configuration ----------------
    task automatic wait_idle();
        while (word_q.size() != 0 || push)
            @(posedge clk);
        while (expected_insts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dict(logic [bmcd_pkg::WORD_W-1:0] vals[bmcd_pkg::DICT_N]);
        for (int i = 0; i <= bmcd_pkg::DICT_N; i++) begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= (i == bmcd_pkg::DICT_N) ? CFG_UNUSED
                                                 : CFG_DICT_WORD0 + bmcd_pkg::CFG_IDX_W'(i);
            cfg_data  <= (i == bmcd_pkg::DICT_N) ? $urandom() : vals[i];
            do @(posedge clk); while (!cfg_ready);
            if (i < bmcd_pkg::DICT_N)
                dict_model[i] = vals[i];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        dict_settings++;
    endtask

    // ---------------- driver ----------------
    always @(negedge clk) begin
        stream_word_t sw;
        if (push && !took) begin
            // Word still offered; hold it.
        end else begin
            took = 1'b0;
            if (gap_cnt > 0) begin
                gap_cnt--;
                push <= 1'b0;
            end else if (word_q.size() > 0) begin
                sw = word_q.pop_front();
                push <= 1'b1;
                packed_word <= sw.word;
                final_word <= sw.last;
                burst_cnt--;
                if (burst_cnt <= 0) begin
                    burst_cnt = $urandom_range(1, 12);
                    gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    always @(negedge clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        if (stall_cnt > 0) begin
            stall_cnt--;
            pop <= 1'b0;
        end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_cnt = 300;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= (rx_cycle % 4 != 0);
                default: pop <= $urandom_range(0, 1);
            endcase
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        bmcd_pkg::out_word_t e;
        if (push && !full) begin
            took = 1'b1;
            words_in++;
            predict_word(packed_word, final_word);
        end
        if (pop && !empty) begin
            if (expected_insts.size() == 0) begin
                $error("unexpected instruction word %h", instruction);
                errors++;
            end else begin
                e = expected_insts.pop_front();
                insts_checked++;
                if (instruction !== e.instruction) begin
                    $error("instruction: expected %h, got %h", e.instruction, instruction);
                    errors++;
                end
                if (run_end !== e.run_end) begin
                    $error("run_end: expected %b, got %b", e.run_end, run_end);
                    errors++;
                end
                if (stream_done !== e.stream_done) begin
                    $error("stream_done: expected %b, got %b", e.stream_done, stream_done);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [bmcd_pkg::WORD_W-1:0] vals[bmcd_pkg::DICT_N];
        foreach (dict_model[i])
            dict_model[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h1234_5678,
                 32'hA5A5_A5A5, 32'h0F0F_0F0F, 32'h7FFF_FFFF, 32'hC3C3_3C3C};
        write_dict(vals);

        // Directed: repeat before any instruction, every tag but padding, edge positions.
        add_code(bmcd_pkg::TAG_REPEAT, 32'd3);
        for (int d = 0; d < bmcd_pkg::DICT_N; d++)
            add_code(bmcd_pkg::TAG_DICT, d);
        add_code(bmcd_pkg::TAG_MASK4, {5'd0, 4'hF, 3'd1});
        add_code(bmcd_pkg::TAG_MASK4, {5'd31, 4'hF, 3'd0});
        add_code(bmcd_pkg::TAG_MASK4, {5'd29, 4'hB, 3'd3});
        add_code(bmcd_pkg::TAG_FLIP1, {5'd0, 3'd0});
        add_code(bmcd_pkg::TAG_FLIP1, {5'd31, 3'd1});
        add_code(bmcd_pkg::TAG_FLIP2, {5'd31, 3'd0});
        add_code(bmcd_pkg::TAG_FLIP2, {5'd0, 3'd1});
        add_code(bmcd_pkg::TAG_FLIP_PAIR, {5'd7, 5'd7, 3'd4});
        add_code(bmcd_pkg::TAG_FLIP_PAIR, {5'd0, 5'd31, 3'd0});
        add_raw(32'h0000_0000);
        add_raw(32'hFFFF_FFFF);
        add_code(bmcd_pkg::TAG_REPEAT, 32'd0);
        align_stream();
        wait_idle();

        foreach (vals[i])
            vals[i] = $urandom();
        write_dict(vals);
        while (word_q.size() < 55) begin
            add_random_code();
            pack_words(1'b0);
        end
        align_stream();
        // The sender pauses here until every instruction has come out.
        wait_idle();
        while (word_q.size() < 55) begin
            add_random_code();
            pack_words(1'b0);
        end
        align_stream();
        wait_idle();

        foreach (vals[i])
            vals[i] = (i == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        write_dict(vals);
        long_stall_req = 1'b1;
        while (word_q.size() < 100) begin
            add_random_code();
            pack_words(1'b0);
        end
        align_stream();
        // Stream end: either padding or an incomplete code left in the final word.
        if ($urandom_range(0, 1) != 0)
            add_code(bmcd_pkg::TAG_REPEAT, $urandom_range(0, 3));
        if ($urandom_range(0, 1) != 0)
            add_code(bmcd_pkg::TAG_PAD, 32'd0);
        else
            add_code(bmcd_pkg::TAG_RAW, 32'd0);
        while (code_bits.size() < 32)
            code_bits = {code_bits, 1'($urandom_range(0, 1))};
        pack_words(1'b1);
        // Words after the end of the stream are dropped by the block.
        for (int i = 0; i < 3; i++)
            add_raw($urandom());
        pack_words($urandom_range(0, 1));
        code_bits.delete();
        wait_idle();

        $display("Run covered %0d compressed words, %0d instructions checked, %0d dictionaries.",
                 words_in, insts_checked, dict_settings);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
